>>> rtl/core/tsd_pkg.sv
// Package for the traffic spike detector: constants, register codes and payload types.
// Used by the top level; depends on nothing.
package tsd_pkg;

    // Default number of archived windows kept in the history ring.
    localparam int HISTORY_DEPTH_DEF = 60;

    // Field widths of the channels and the configuration port.
    localparam int OP_W      = 2;
    localparam int TIME_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int BYTES_W   = 64;
    localparam int STORED_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int PCT_W     = 10;
    localparam int WIN_W     = 16;
    localparam int HIST_W    = 2 * COUNT_W;

    // Event codes; the unused code behaves as a time tick.
    localparam logic [OP_W-1:0] OP_CONN = 2'd0;
    localparam logic [OP_W-1:0] OP_PKT  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BASELINE = 2'd0,
        CFG_SPIKE_PCT    = 2'd1,
        CFG_WINDOW_MS    = 2'd2
    } tsd_cfg_idx_t;

    // Register reset values.
    localparam logic [CFG_W-1:0] MIN_BASELINE_RST = 32'd0;
    localparam logic [PCT_W-1:0] SPIKE_PCT_RST    = 10'd200;
    localparam logic [WIN_W-1:0] WINDOW_MS_RST    = 16'd1000;

    // Units of the baseline register per archived window needed.
    localparam logic [CFG_W-1:0] BASELINE_DIV = 32'd60;

    // x / 100 for any 32-bit x equals (x * RECIP_100) >> RECIP_SHIFT.
    localparam logic [COUNT_W-1:0] RECIP_100   = 32'h51EB_851F;
    localparam int                 RECIP_SHIFT = 37;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TIME_W-1:0] time_ms;
        logic [SIZE_W-1:0] packet_size;
    } tsd_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  conn_in_window;
        logic [COUNT_W-1:0]  pkts_in_window;
        logic [BYTES_W-1:0]  bytes_in_window;
        logic [STORED_W-1:0] windows_stored;
        logic                rolled_over;
        logic                attack_detected;
    } tsd_out_t;

endpackage

>>> rtl/core/tsd_stream_if.sv
// Valid/ready stream interface carrying one payload per transfer.
// The payload type is a parameter; the detector uses the structs of tsd_pkg.
interface tsd_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/traffic_spike_detector.sv
// Traffic spike detector top level: window counters, history ring and spike check.
// Depends on tsd_pkg, tsd_stream_if and tsd_ram.
//
// Usage. Events arrive on the sink channel "events": an operation code (connection,
// packet or time tick), the current time in milliseconds and a packet size. Each
// event yields exactly one transfer on the source channel "results" with the window
// counts, the number of archived windows, a rollover flag and the attack flag.
// Registers are written through cfg_we/cfg_index/cfg_data while no event is in
// flight; a write takes effect at the next clock edge.
//
// Timing. One event at a time: after a transfer, the S_ARCH state updates the window and
// the history ring and the S_CHK state checks the baseline. When detection is armed,
// the connection and packet averages are then formed one after the other on a shared
// divider that retires two quotient bits per cycle, each followed by two multiplies
// and a threshold store. The result is then loaded in S_OUT once the output register
// is free, and the block returns to S_IDLE to take the next event.
//
// Reset clears the counters, ring pointers and sums and restores register defaults;
// the history RAM is not cleared, since an entry is read back only once the ring is
// full. While the receiver stalls, the result waits in the output register; the
// block still takes and processes the next event and holds its result until then.
module traffic_spike_detector #(
    parameter int HISTORY_DEPTH = tsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tsd_stream_if.sink                     events,
    tsd_stream_if.source                   results,
    input  logic                           cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsd_pkg::CFG_W-1:0]      cfg_data
);

    // Ring count must hold the depth itself; the pointer only indexes it.
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    // Sums of up to HISTORY_DEPTH 32-bit counts never wrap at this width.
    localparam int SUM_W     = tsd_pkg::COUNT_W + CNT_W;
    localparam int DIV_BITS  = 2;
    localparam int DIV_W     = ((SUM_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CW        = tsd_pkg::COUNT_W;
    localparam int PROD_W    = 2 * CW;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ARCH = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MUL1 = 8'b0001_0000,
        S_MUL2 = 8'b0010_0000,
        S_THR  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } tsd_state_t;

    // Control state and registers, cleared or restored to defaults by reset.
    tsd_state_t                    state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tsd_pkg::CFG_W-1:0]     min_reg;
    logic [tsd_pkg::PCT_W-1:0]     pct_reg;
    logic [tsd_pkg::WIN_W-1:0]     win_reg;
    logic [tsd_pkg::TIME_W-1:0]    window_start_reg, window_start_next;
    logic [CW-1:0]                 conn_reg, conn_next;
    logic [CW-1:0]                 pkt_reg, pkt_next;
    logic [tsd_pkg::BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              ring_count_reg, ring_count_next;
    logic [SUM_W-1:0]              sum_conn_reg, sum_conn_next;
    logic [SUM_W-1:0]              sum_pkt_reg, sum_pkt_next;

    // Datapath registers, no reset needed.
    logic [tsd_pkg::OP_W-1:0]      op_reg, op_next;
    logic [tsd_pkg::TIME_W-1:0]    time_reg, time_next;
    logic [tsd_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic                          roll_reg, roll_next;
    logic                          arch_reg, arch_next;
    logic                          armed_reg, armed_next;
    logic                          lane_reg, lane_next;
    logic [DIV_W-1:0]              div_q_reg, div_q_next;
    logic [CNT_W-1:0]              div_r_reg, div_r_next;
    logic [DCNT_W-1:0]             div_cnt_reg, div_cnt_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [CW-1:0]                 thr_conn_reg, thr_conn_next;
    logic [CW-1:0]                 thr_pkt_reg, thr_pkt_next;
    tsd_pkg::tsd_out_t             res_reg, res_next;

    // History RAM: connection count in the upper half, packet count below.
    logic                          ram_we;
    logic [tsd_pkg::HIST_W-1:0]    ram_rdata;

    // Divider step and shared multiplier operands.
    logic [CNT_W-1:0]              div_r_step;
    logic [DIV_W-1:0]              div_q_step;
    logic [CW-1:0]                 mul_a;
    logic [CW-1:0]                 mul_b;
    logic                          ring_full;
    logic [CW-1:0]                 old_conn;
    logic [CW-1:0]                 old_pkt;
    logic [CW-1:0]                 needed;
    logic [CW-1:0]                 thr_now;
    logic                          event_xfer;

    assign event_xfer     = events.valid && events.ready;
    assign events.ready   = (state_reg == S_IDLE);
    assign results.valid  = out_valid_reg;
    assign results.payload = res_reg;

    assign ring_full = (ring_count_reg == CNT_W'(HISTORY_DEPTH));
    assign old_conn  = ring_full ? ram_rdata[tsd_pkg::HIST_W-1:CW] : '0;
    assign old_pkt   = ring_full ? ram_rdata[CW-1:0] : '0;
    // n < floor(min/60) holds exactly when 60 * (n + 1) <= min.
    assign needed    = (CW'(ring_count_reg) + CW'(1)) * tsd_pkg::BASELINE_DIV;
    assign thr_now   = CW'(prod_reg[PROD_W-1:tsd_pkg::RECIP_SHIFT]);

    // The read address follows the head, so the oldest entry is ready in S_ARCH.
    tsd_ram #(
        .WIDTH (tsd_pkg::HIST_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata ({conn_reg, pkt_reg}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Restoring divider: two quotient bits per cycle. The remainder stays below
    // the ring count, so the trial compare is only as wide as the count.
    always_comb
    begin : div_step
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        rem = div_r_reg;
        quo = div_q_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial = {rem, quo[DIV_W-1]};
            quo   = {quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, ring_count_reg})
            begin
                trial  = trial - {1'b0, ring_count_reg};
                quo[0] = 1'b1;
            end
            rem = trial[CNT_W-1:0];
        end
        div_r_step = rem;
        div_q_step = quo;
    end

    // The one multiplier first scales the average by the percent, then
    // multiplies that product by the reciprocal of one hundred.
    always_comb
    begin
        if (state_reg == S_MUL2)
        begin
            mul_a = prod_reg[CW-1:0];
            mul_b = tsd_pkg::RECIP_100;
        end
        else
        begin
            mul_a = div_q_reg[CW-1:0];
            mul_b = CW'(pct_reg);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        window_start_next = window_start_reg;
        conn_next         = conn_reg;
        pkt_next          = pkt_reg;
        bytes_next        = bytes_reg;
        head_next         = head_reg;
        ring_count_next   = ring_count_reg;
        sum_conn_next     = sum_conn_reg;
        sum_pkt_next      = sum_pkt_reg;
        op_next           = op_reg;
        time_next         = time_reg;
        size_next         = size_reg;
        roll_next         = roll_reg;
        arch_next         = arch_reg;
        armed_next        = armed_reg;
        lane_next         = lane_reg;
        div_q_next        = div_q_reg;
        div_r_next        = div_r_reg;
        div_cnt_next      = div_cnt_reg;
        prod_next         = prod_reg;
        thr_conn_next     = thr_conn_reg;
        thr_pkt_next      = thr_pkt_reg;
        res_next          = res_reg;
        ram_we            = 1'b0;

        // A waiting result leaves as soon as the receiver takes it.
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (event_xfer)
                begin
                    op_next   = events.payload.operation;
                    time_next = events.payload.time_ms;
                    size_next = events.payload.packet_size;
                    // Elapsed time is taken modulo 2^32.
                    roll_next = (events.payload.time_ms - window_start_reg)
                                > tsd_pkg::TIME_W'(win_reg);
                    arch_next = ((events.payload.time_ms - window_start_reg)
                                > tsd_pkg::TIME_W'(win_reg))
                                && (window_start_reg != '0);
                    state_next = S_ARCH;
                end
            end

            S_ARCH:
            begin
                // Archive the closing window; a full ring drops its oldest entry.
                if (arch_reg)
                begin
                    ram_we        = 1'b1;
                    sum_conn_next = sum_conn_reg - SUM_W'(old_conn) + SUM_W'(conn_reg);
                    sum_pkt_next  = sum_pkt_reg - SUM_W'(old_pkt) + SUM_W'(pkt_reg);
                    head_next     = (head_reg == PTR_W'(HISTORY_DEPTH - 1))
                                    ? '0 : head_reg + PTR_W'(1);
                    if (!ring_full)
                    begin
                        ring_count_next = ring_count_reg + CNT_W'(1);
                    end
                end
                if (roll_reg)
                begin
                    window_start_next = time_reg;
                end
                conn_next  = (roll_reg ? '0 : conn_reg)
                             + CW'(op_reg == tsd_pkg::OP_CONN);
                pkt_next   = (roll_reg ? '0 : pkt_reg)
                             + CW'(op_reg == tsd_pkg::OP_PKT);
                bytes_next = (roll_reg ? '0 : bytes_reg)
                             + ((op_reg == tsd_pkg::OP_PKT)
                                ? tsd_pkg::BYTES_W'(size_reg) : '0);
                state_next = S_CHK;
            end

            S_CHK:
            begin
                // Detection is armed once the ring holds at least one and at least floor(min/60) windows.
                armed_next = (ring_count_reg != '0) && (needed > min_reg);
                if ((ring_count_reg != '0) && (needed > min_reg))
                begin
                    lane_next    = 1'b0;
                    div_q_next   = DIV_W'(sum_conn_reg);
                    div_r_next   = '0;
                    div_cnt_next = DCNT_W'(DIV_STEPS - 1);
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_DIV:
            begin
                div_q_next = div_q_step;
                div_r_next = div_r_step;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DCNT_W'(1);
                end
            end

            S_MUL1:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_THR;
            end

            S_THR:
            begin
                if (!lane_reg)
                begin
                    thr_conn_next = thr_now;
                    lane_next     = 1'b1;
                    div_q_next    = DIV_W'(sum_pkt_reg);
                    div_r_next    = '0;
                    div_cnt_next  = DCNT_W'(DIV_STEPS - 1);
                    state_next    = S_DIV;
                end
                else
                begin
                    thr_pkt_next = thr_now;
                    state_next   = S_OUT;
                end
            end

            S_OUT:
            begin
                // Load only into a free output register.
                if (!out_valid_reg || results.ready)
                begin
                    res_next.conn_in_window  = conn_reg;
                    res_next.pkts_in_window  = pkt_reg;
                    res_next.bytes_in_window = bytes_reg;
                    res_next.windows_stored  = tsd_pkg::STORED_W'(ring_count_reg);
                    res_next.rolled_over     = roll_reg;
                    res_next.attack_detected = armed_reg
                        && (((thr_conn_reg != '0) && (conn_reg > thr_conn_reg))
                            || ((thr_pkt_reg != '0) && (pkt_reg > thr_pkt_reg)));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            window_start_reg <= '0;
            conn_reg         <= '0;
            pkt_reg          <= '0;
            bytes_reg        <= '0;
            head_reg         <= '0;
            ring_count_reg   <= '0;
            sum_conn_reg     <= '0;
            sum_pkt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            window_start_reg <= window_start_next;
            conn_reg         <= conn_next;
            pkt_reg          <= pkt_next;
            bytes_reg        <= bytes_next;
            head_reg         <= head_next;
            ring_count_reg   <= ring_count_next;
            sum_conn_reg     <= sum_conn_next;
            sum_pkt_reg      <= sum_pkt_next;
        end
    end

    // Configuration registers; writes to indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= tsd_pkg::MIN_BASELINE_RST;
            pct_reg <= tsd_pkg::SPIKE_PCT_RST;
            win_reg <= tsd_pkg::WINDOW_MS_RST;
        end
        else if (cfg_we)
        begin
            case (tsd_pkg::tsd_cfg_idx_t'(cfg_index))
                tsd_pkg::CFG_MIN_BASELINE: min_reg <= cfg_data;
                tsd_pkg::CFG_SPIKE_PCT:    pct_reg <= cfg_data[tsd_pkg::PCT_W-1:0];
                tsd_pkg::CFG_WINDOW_MS:    win_reg <= cfg_data[tsd_pkg::WIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        time_reg     <= time_next;
        size_reg     <= size_next;
        roll_reg     <= roll_next;
        arch_reg     <= arch_next;
        armed_reg    <= armed_next;
        lane_reg     <= lane_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        div_cnt_reg  <= div_cnt_next;
        prod_reg     <= prod_next;
        thr_conn_reg <= thr_conn_next;
        thr_pkt_reg  <= thr_pkt_next;
        res_reg      <= res_next;
    end

    // The ring never holds more windows than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("ring count exceeds history depth");

    // The ring count only ever grows by one window at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ring_count_reg != $past(ring_count_reg))
        |-> (ring_count_reg == $past(ring_count_reg) + CNT_W'(1)))
        else $error("ring count changed by more than one");

    // An empty ring has empty sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ring_count_reg == '0) |-> ((sum_conn_reg == '0) && (sum_pkt_reg == '0)))
        else $error("nonzero sum with empty ring");

    // An accepted event always goes to the archive step next.
    assert property (@(posedge clk) disable iff (!rst_n)
        event_xfer |=> (state_reg == S_ARCH))
        else $error("event transfer did not start processing");

    // The divider remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_r_reg < ring_count_reg))
        else $error("divider remainder out of range");

endmodule

>>> rtl/core/tsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the archived window counts of the detector.
module tsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
